@@ src/kqs_pkg.sv @@
package kqs_pkg;

  // configuration register indexes
  localparam int unsigned RegKeyIsSigned    = 0;
  localparam int unsigned RegOrderDescending = 1;

  // sort sequencer state codes
  localparam logic [3:0] StLoad    = 4'd0;
  localparam logic [3:0] StPop     = 4'd1;
  localparam logic [3:0] StPivRd   = 4'd2;
  localparam logic [3:0] StPivCmp  = 4'd3;
  localparam logic [3:0] StSwapRd  = 4'd4;
  localparam logic [3:0] StSwapWr  = 4'd5;
  localparam logic [3:0] StLeftCmp = 4'd6;
  localparam logic [3:0] StRightCmp = 4'd7;
  localparam logic [3:0] StPush    = 4'd8;
  localparam logic [3:0] StEmitRd  = 4'd9;
  localparam logic [3:0] StEmit    = 4'd10;
  localparam logic [3:0] StSwapWr2 = 4'd11;
  localparam logic [3:0] StPopRd   = 4'd12;

  // compare mode travelling into the comparator
  typedef struct packed {
    logic is_signed;
    logic descending;
  } cmp_mode_t;

endpackage

@@ src/key_quicksort_top.sv @@
// Batch key sorter. Keys arrive one per request on the slave stream; the request with
// s_axis_tlast set closes the batch. The stored keys (up to MAX_KEYS, extra keys are
// dropped and flag overflow) are then sorted in place by a quicksort whose pivot is the
// later in sort order of the first two distinct keys in a range and whose split is a
// Hoare-style partition, driven by an explicit range stack. All work runs through one
// shared comparator and a single-port key memory, one memory access per cycle. Keys
// are taken only in the load state while no output key is pending; while sorting and
// emitting the block accepts nothing. Sorted keys leave on the master stream, tlast on
// the final key, tuser carrying the overflow flag. Registers: 0x0 key_is_signed, 0x4
// order_descending (bit 0 each).
module key_quicksort_top import kqs_pkg::*; #(
  parameter int unsigned MAX_KEYS  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // key_in[31:0]
  input  logic        s_axis_tlast_i,   // batch_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // key_out[31:0]
  output logic        m_axis_tlast_o,   // run_end
  output logic        m_axis_tuser_o,   // overflowed
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned SD = MAX_KEYS; // range stack depth
  localparam int unsigned SW = $clog2(SD + 1);

  // configuration
  logic signed_q, desc_q;
  cmp_mode_t mode;
  assign mode = '{is_signed: signed_q, descending: desc_q};
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q <= 1'b0;
      desc_q   <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i) begin
      if (paddr_i[2] == 1'(RegOrderDescending)) desc_q <= pwdata_i[0];
      else signed_q <= pwdata_i[0];
    end
  end
  assign prdata_o = {31'd0, (paddr_i[2] == 1'(RegOrderDescending)) ? desc_q : signed_q};

  // sequencer state
  logic [3:0]      st_q, st_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [IW-1:0]   lo_q, lo_d, hi_q, hi_d, left_q, left_d, right_q, right_d;
  logic [IW-1:0]   k_q, k_d;
  logic [KEY_WIDTH-1:0] piv_key_q, piv_key_d, ref_key_q, ref_key_d, tmp_q, tmp_d;
  logic [CW-1:0]   emit_q, emit_d;
  logic [SW-1:0]   sp_q, sp_d;
  logic [IW-1:0]   stk_lo [SD];
  logic [IW-1:0]   stk_hi [SD];
  logic [IW-1:0]   stk_top_lo_q, stk_top_hi_q;
  logic            out_v_q, out_v_d, out_l_q, out_l_d;
  logic [31:0]     out_k_q, out_k_d;

  // key memory: one access per cycle, registered read
  logic [KEY_WIDTH-1:0] mem [MAX_KEYS];
  logic [KEY_WIDTH-1:0] rd_q;
  logic                 we;
  logic [IW-1:0]        addr;
  logic [KEY_WIDTH-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rd_q <= mem[addr];
  end

  // range stack, top entry read into a register
  logic push;
  logic [IW-1:0] push_lo, push_hi;
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_lo[sp_q[IW-1:0]] <= push_lo;
      stk_hi[sp_q[IW-1:0]] <= push_hi;
    end
    stk_top_lo_q <= stk_lo[sp_q[IW-1:0] - 1'b1];
    stk_top_hi_q <= stk_hi[sp_q[IW-1:0] - 1'b1];
  end

  // shared comparator
  logic [KEY_WIDTH-1:0] ca, cb;
  logic lt, gt;
  kqs_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (
    .mode_i(mode), .a_i(ca), .b_i(cb), .lt_o(lt), .gt_o(gt)
  );

  logic in_acc;
  assign s_axis_tready_o = (st_q == StLoad) && !out_v_q;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; ovf_d = ovf_q;
    lo_d = lo_q; hi_d = hi_q; left_d = left_q; right_d = right_q;
    k_d = k_q; piv_key_d = piv_key_q; ref_key_d = ref_key_q; tmp_d = tmp_q;
    emit_d = emit_q; sp_d = sp_q; out_v_d = out_v_q; out_l_d = out_l_q; out_k_d = out_k_q;
    we = 1'b0; addr = left_q; wdata = tmp_q;
    push = 1'b0; push_lo = lo_q; push_hi = left_q - 1'b1;
    ca = rd_q; cb = ref_key_q;
    unique case (st_q)
      StLoad: begin
        addr = cnt_q[IW-1:0];
        wdata = KEY_WIDTH'(s_axis_tdata_i);
        if (in_acc) begin
          if (cnt_q < CW'(MAX_KEYS)) begin
            we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else ovf_d = 1'b1;
          if (s_axis_tlast_i) begin
            // push whole range, count is at least one after this request
            push = 1'b1; push_lo = '0;
            push_hi = (cnt_q < CW'(MAX_KEYS)) ? cnt_q[IW-1:0] : IW'(MAX_KEYS - 1);
            sp_d = SW'(1);
            st_d = StPop;
          end
        end
      end
      StPop: begin
        if (sp_q == '0) begin
          emit_d = '0; st_d = StEmitRd;
        end else begin
          sp_d = sp_q - 1'b1;
          st_d = StPopRd;
        end
      end
      StPopRd: begin
        // top entry registered during the pop cycle
        lo_d = stk_top_lo_q;
        hi_d = stk_top_hi_q;
        if (stk_top_lo_q < stk_top_hi_q) begin
          addr = stk_top_lo_q;
          k_d = stk_top_lo_q + 1'b1;
          st_d = StPivRd;
        end else st_d = StPop;
      end
      StPivRd: begin
        // rd_q holds key[lo]
        ref_key_d = rd_q;
        addr = k_q;
        st_d = StPivCmp;
      end
      StPivCmp: begin
        // compare key[k] against key[lo]
        if (gt) begin
          piv_key_d = rd_q;
          left_d = lo_q; right_d = hi_q; addr = lo_q; st_d = StSwapRd;
        end else if (lt) begin
          piv_key_d = ref_key_q;
          left_d = lo_q; right_d = hi_q; addr = lo_q; st_d = StSwapRd;
        end else if (k_q == hi_q) begin
          st_d = StPop;
        end else begin
          addr = k_q + 1'b1;
          k_d = k_q + 1'b1;
        end
      end
      StSwapRd: begin
        // rd_q = key[left]; fetch key[right]
        tmp_d = rd_q;
        addr = right_q;
        st_d = StSwapWr;
      end
      StSwapWr: begin
        // write key[right] into left
        we = 1'b1; addr = left_q; wdata = rd_q;
        st_d = StSwapWr2;
      end
      StSwapWr2: begin
        we = 1'b1; addr = right_q; wdata = tmp_q;
        st_d = StLeftCmp;
      end
      StLeftCmp: begin
        // read address left issued last cycle? issue now, compare next
        addr = left_q;
        st_d = StRightCmp;
        k_d = '0;
      end
      StRightCmp: begin
        cb = piv_key_q;
        if (k_q == '0) begin
          // rd_q = key[left]
          if (left_q < hi_q && lt) begin
            left_d = left_q + 1'b1;
            addr = left_q + 1'b1;
          end else begin
            k_d = IW'(1);
            addr = right_q;
          end
        end else begin
          // rd_q = key[right]
          if (right_q > lo_q && !lt) begin
            right_d = right_q - 1'b1;
            addr = right_q - 1'b1;
          end else if (left_q <= right_q) begin
            addr = left_q;
            st_d = StSwapRd;
          end else begin
            st_d = StPush;
          end
        end
      end
      StPush: begin
        // left is mid; push (mid,hi) then (lo,mid-1) so the lower range goes first
        if (left_q > lo_q && left_q <= hi_q) begin
          push = 1'b1;
          sp_d = sp_q + 1'b1;
          if (k_q != '0) begin
            push_lo = left_q; push_hi = hi_q;
            k_d = '0;
          end else begin
            push_lo = lo_q; push_hi = left_q - 1'b1;
            st_d = StPop;
          end
        end else st_d = StPop;
      end
      StEmitRd: begin
        addr = emit_q[IW-1:0];
        if (!out_v_q || m_axis_tready_i) st_d = StEmit;
      end
      StEmit: begin
        if (!out_v_q || m_axis_tready_i) begin
          out_v_d = 1'b1;
          out_k_d = 32'(rd_q);
          out_l_d = (emit_q + 1'b1 == cnt_q);
          emit_d = emit_q + 1'b1;
          if (emit_q + 1'b1 == cnt_q) begin
            st_d = StLoad; cnt_d = '0;
          end else st_d = StEmitRd;
        end
      end
      default: st_d = StLoad;
    endcase
    if (out_v_q && m_axis_tready_i && !(st_q == StEmit)) out_v_d = 1'b0;
    if (out_v_q && m_axis_tready_i && out_l_q) ovf_d = 1'b0;
  end

  logic out_ovf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; cnt_q <= '0; ovf_q <= 1'b0; sp_q <= '0; out_v_q <= 1'b0;
      out_l_q <= 1'b0; emit_q <= '0; k_q <= '0; out_ovf_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; sp_q <= sp_d; out_v_q <= out_v_d;
      out_l_q <= out_l_d; emit_q <= emit_d; k_q <= k_d;
      ovf_q <= (st_q == StEmit && st_d == StLoad) ? 1'b0 : ovf_d;
      if (st_q == StEmit && st_d != StEmit) out_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; left_q <= left_d; right_q <= right_d;
    piv_key_q <= piv_key_d; ref_key_q <= ref_key_d; tmp_q <= tmp_d;
    out_k_q <= out_k_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_k_q;
  assign m_axis_tlast_o  = out_l_q;
  assign m_axis_tuser_o  = out_ovf_q;

  // no input taken while a batch is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StLoad) |-> !s_axis_tready_o) else $error("ready outside load");
  // stored count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_KEYS)) else $error("count overrun");
  // range stack stays within its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SW'(SD)) else $error("stack overrun");

endmodule

@@ src/kqs_cmp.sv @@
module kqs_cmp import kqs_pkg::*; #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  cmp_mode_t              mode_i,
  input  logic [KEY_WIDTH-1:0]   a_i,
  input  logic [KEY_WIDTH-1:0]   b_i,
  output logic                   lt_o,
  output logic                   gt_o
);

  logic [KEY_WIDTH-1:0] a_adj, b_adj;
  logic a_lt, a_gt;

  always_comb begin
    a_adj = a_i;
    b_adj = b_i;
    // flip the sign bit so an unsigned compare orders two's complement keys
    if (mode_i.is_signed) begin
      a_adj[KEY_WIDTH-1] = ~a_i[KEY_WIDTH-1];
      b_adj[KEY_WIDTH-1] = ~b_i[KEY_WIDTH-1];
    end
    a_lt = a_adj < b_adj;
    a_gt = a_adj > b_adj;
    lt_o = mode_i.descending ? a_gt : a_lt;
    gt_o = mode_i.descending ? a_lt : a_gt;
  end

endmodule
